// File: src/rmsedf_pkg.sv
// shared constants, codes and controller/datapath interface types
package rmsedf_pkg;

  localparam int MAX_TASKS      = 8;
  localparam int TIME_BITS      = 16;
  localparam int WIDE_BITS      = TIME_BITS + 2;
  localparam int SLOT_BITS      = $clog2(MAX_TASKS);
  localparam int MASK_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_POLICY_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SIM_LENGTH  = 2'd1;

  typedef struct packed {
    logic load;
    logic emit_halt;
    logic scan_init;
    logic scan_step;
    logic finish;
    logic dl_fix;
  } ctrl_cmd_t;

  typedef struct packed {
    logic halt_now;
    logic scan_last;
    logic job_ends;
  } ctrl_status_t;

endpackage

// File: src/rmsedf_ctrl.sv
// controller state machine: request decode, slot scan sequencing, job update
module rmsedf_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    op,
  input  rmsedf_pkg::ctrl_status_t status,
  output rmsedf_pkg::ctrl_cmd_t    cmd,
  output logic                    busy
);
  import rmsedf_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_DLFIX  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else if (status.halt_now) begin
            cmd.emit_halt = 1'b1;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = status.job_ends ? S_DLFIX : S_IDLE;
      end
      S_DLFIX: begin
        cmd.dl_fix = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

// File: src/rmsedf_dp.sv
// datapath: task table, time, config registers, scan selection and results
module rmsedf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rmsedf_pkg::ctrl_cmd_t                 cmd,
  output rmsedf_pkg::ctrl_status_t              status,
  input  logic                                 cfg_valid,
  input  logic [rmsedf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rmsedf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [2:0]                           task_slot,
  input  logic [15:0]                          first_release,
  input  logic [15:0]                          exec_time,
  input  logic [15:0]                          first_deadline,
  input  logic [15:0]                          task_period_in,
  output logic                                 done,
  output logic [7:0]                           arrive_mask,
  output logic                                 run_valid,
  output logic [2:0]                           run_task,
  output logic                                 start_flag,
  output logic                                 end_flag,
  output logic                                 miss_flag,
  output logic [2:0]                           miss_task,
  output logic                                 halted
);
  import rmsedf_pkg::*;

  logic [WIDE_BITS-1:0] job_release  [MAX_TASKS];
  logic [WIDE_BITS-1:0] job_deadline [MAX_TASKS];
  logic [15:0]          job_period   [MAX_TASKS];
  logic [15:0]          job_exec     [MAX_TASKS];
  logic [15:0]          job_progress [MAX_TASKS];
  logic [MAX_TASKS-1:0] slot_enabled;
  logic [MAX_TASKS-1:0] arrival_seen;
  logic [TIME_BITS-1:0] now_tick;
  logic                 stopped;
  logic                 policy_mode;
  logic [15:0]          sim_length;

  logic [SLOT_BITS-1:0] idx;
  logic [MASK_BITS-1:0] mask;
  logic                 miss;
  logic [SLOT_BITS-1:0] miss_slot;
  logic                 found;
  logic [SLOT_BITS-1:0] run;
  logic [WIDE_BITS-1:0] best_key;
  logic [WIDE_BITS-1:0] best_rel;
  logic [15:0]          best_per;
  logic [15:0]          best_prog;
  logic [15:0]          best_exec;

  logic [SLOT_BITS-1:0] load_idx;
  logic                 load_ok;
  logic [WIDE_BITS-1:0] now_wide;
  logic                 cur_en;
  logic [WIDE_BITS-1:0] cur_rel;
  logic [WIDE_BITS-1:0] cur_key;
  logic                 cur_arrive;
  logic                 cur_miss;
  logic                 cur_cand;
  logic [15:0]          prog_inc;
  logic [WIDE_BITS-1:0] rel_next;
  logic                 ends;

  assign load_idx   = SLOT_BITS'(task_slot);
  assign load_ok    = (32'(task_slot) < MAX_TASKS);
  assign now_wide   = WIDE_BITS'(now_tick);
  assign cur_en     = slot_enabled[idx];
  assign cur_rel    = job_release[idx];
  assign cur_key    = policy_mode ? job_deadline[idx] : WIDE_BITS'(job_period[idx]);
  assign cur_arrive = cur_en && (cur_rel == now_wide) && !arrival_seen[idx];
  assign cur_miss   = cur_en && (job_deadline[idx] < now_wide);
  assign cur_cand   = cur_en && (cur_rel <= now_wide);
  assign prog_inc   = best_prog + 16'd1;
  assign rel_next   = best_rel + WIDE_BITS'(best_per);
  assign ends       = found && !miss && (prog_inc >= best_exec);

  assign status.halt_now  = stopped || (now_tick >= TIME_BITS'(sim_length));
  assign status.scan_last = (idx == SLOT_BITS'(MAX_TASKS - 1));
  assign status.job_ends  = ends;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= 1'b0;
      sim_length  <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POLICY_MODE: policy_mode <= cfg_data[0];
        CFG_SIM_LENGTH:  sim_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // task table and time
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_enabled <= '0;
      arrival_seen <= '0;
      now_tick     <= '0;
      stopped      <= 1'b0;
    end else begin
      if (cmd.load && load_ok) begin
        job_release[load_idx]  <= WIDE_BITS'(first_release);
        job_exec[load_idx]     <= exec_time;
        job_deadline[load_idx] <= WIDE_BITS'(first_deadline);
        job_period[load_idx]   <= task_period_in;
        job_progress[load_idx] <= '0;
        slot_enabled[load_idx] <= 1'b1;
        arrival_seen[load_idx] <= 1'b0;
      end
      if (cmd.scan_step && cur_arrive) arrival_seen[idx] <= 1'b1;
      if (cmd.finish) begin
        if (miss) begin
          stopped <= 1'b1;
        end else begin
          now_tick <= now_tick + TIME_BITS'(1);
          if (found) begin
            if (ends) begin
              job_release[run]  <= rel_next;
              job_progress[run] <= '0;
            end else begin
              job_progress[run] <= prog_inc;
            end
          end
        end
      end
      if (cmd.dl_fix) job_deadline[run] <= rel_next;
    end
  end

  // scan selection
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      idx   <= '0;
      mask  <= '0;
      miss  <= 1'b0;
      found <= 1'b0;
    end
    if (cmd.scan_step) begin
      idx <= idx + SLOT_BITS'(1);
      if (cur_arrive && (32'(idx) < MASK_BITS)) mask[idx] <= 1'b1;
      if (cur_miss && !miss) begin
        miss      <= 1'b1;
        miss_slot <= idx;
      end
      if (cur_cand && (!found || (cur_key < best_key))) begin
        found     <= 1'b1;
        run       <= idx;
        best_key  <= cur_key;
        best_rel  <= cur_rel;
        best_per  <= job_period[idx];
        best_prog <= job_progress[idx];
        best_exec <= job_exec[idx];
      end
    end
    if (cmd.finish && ends) best_rel <= rel_next;
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_halt || cmd.finish;
    end
    if (cmd.emit_halt) begin
      arrive_mask <= '0;
      run_valid   <= 1'b0;
      run_task    <= '0;
      start_flag  <= 1'b0;
      end_flag    <= 1'b0;
      miss_flag   <= 1'b0;
      miss_task   <= '0;
      halted      <= 1'b1;
    end else if (cmd.finish) begin
      arrive_mask <= 8'(mask);
      if (miss) begin
        run_valid  <= 1'b0;
        run_task   <= '0;
        start_flag <= 1'b0;
        end_flag   <= 1'b0;
        miss_flag  <= 1'b1;
        miss_task  <= 3'(miss_slot);
        halted     <= 1'b1;
      end else begin
        run_valid  <= found;
        run_task   <= found ? 3'(run) : 3'd0;
        start_flag <= found && (best_prog == 16'd0);
        end_flag   <= ends;
        miss_flag  <= 1'b0;
        miss_task  <= '0;
        halted     <= 1'b0;
      end
    end
  end

endmodule

// File: src/rms_edf_tick_scheduler.sv
// top level: rate monotonic / edf periodic task scheduler
// load request: taken while idle, no result, busy stays low
// tick request: one slot scanned per cycle, result strobe via the done register
//   after finish; busy in scan, finish and, if the job ends, deadline update
// tick while halted: result strobe on the next cycle; the receiver cannot stall
// synchronous reset clears the task table valid bits, time and halt, and resets config
module rms_edf_tick_scheduler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [2:0]                           task_slot,
  input  logic [15:0]                          first_release,
  input  logic [15:0]                          exec_time,
  input  logic [15:0]                          first_deadline,
  input  logic [15:0]                          task_period_in,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rmsedf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rmsedf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                 done,
  output logic [7:0]                           arrive_mask,
  output logic                                 run_valid,
  output logic [2:0]                           run_task,
  output logic                                 start_flag,
  output logic                                 end_flag,
  output logic                                 miss_flag,
  output logic [2:0]                           miss_task,
  output logic                                 halted
);
  import rmsedf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  rmsedf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  rmsedf_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .task_slot      (task_slot),
    .first_release  (first_release),
    .exec_time      (exec_time),
    .first_deadline (first_deadline),
    .task_period_in (task_period_in),
    .done           (done),
    .arrive_mask    (arrive_mask),
    .run_valid      (run_valid),
    .run_task       (run_task),
    .start_flag     (start_flag),
    .end_flag       (end_flag),
    .miss_flag      (miss_flag),
    .miss_task      (miss_task),
    .halted         (halted)
  );

endmodule
